>>> hdl/spl_pkg.sv
// Shared constants and types for the speed PI loop.
// Used by spl_mul and speed_pi_loop_with_filter_top; no dependencies.
package spl_pkg;

  localparam int FRAC_BITS = 8;
  localparam int COUNT_W   = 16;

  // Filter weight on the new sample: 2^F - round(0.8 * 2^F)
  localparam int COEF_OLD  = ((4 << FRAC_BITS) + 2) / 5;
  localparam int COEF_NEW  = (1 << FRAC_BITS) - COEF_OLD;

  localparam int SUM_W     = COUNT_W + 1;
  localparam int TARGET_W  = SUM_W + FRAC_BITS;
  localparam int FILT_W    = TARGET_W + 1;
  localparam int INTEG_W   = 24;

  localparam int MCAND_W   = FILT_W + 1;
  localparam int MPLR_W    = 16;
  localparam int PROD_W    = MCAND_W + MPLR_W + 1;
  localparam int MCNT_W    = $clog2(MPLR_W);

  localparam int OUT_W     = 16;

  // Register indexes
  localparam logic [2:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [2:0] REG_INTEG_GAIN = 3'd1;
  localparam logic [2:0] REG_INTEG_LIM  = 3'd2;
  localparam logic [2:0] REG_MOVE_SPEED = 3'd3;
  localparam logic [2:0] REG_TILT_LIM   = 3'd4;

  typedef struct packed {
    logic start;
    logic accumulate;
  } mul_cmd_t;

endpackage

>>> hdl/spl_mul.sv
// Bit-serial signed shift-add multiplier, one multiplier bit per cycle.
// Depends on spl_pkg.
module spl_mul import spl_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mul_cmd_t                   cmd_i,
  input  logic signed [MCAND_W-1:0]  mcand_i,
  input  logic signed [MPLR_W-1:0]   mplier_i,
  output logic signed [PROD_W-1:0]   product_o,
  output logic                       done_o
);

  logic [PROD_W-1:0] mcand_q;
  logic [MPLR_W-1:0] mplier_q;
  logic [PROD_W-1:0] acc_q, acc_d, term;
  logic [MCNT_W-1:0] cnt_q;
  logic              busy_q, done_q, last;

  assign last  = (cnt_q == MCNT_W'(MPLR_W - 1));
  assign term  = mplier_q[0] ? mcand_q : '0;
  // sign bit of the multiplier carries negative weight
  assign acc_d = last ? acc_q - term : acc_q + term;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      mcand_q  <= {{(PROD_W-MCAND_W){mcand_i[MCAND_W-1]}}, mcand_i};
      mplier_q <= mplier_i;
      if (!cmd_i.accumulate) begin
        acc_q <= '0;
      end
    end else if (busy_q) begin
      mcand_q  <= {mcand_q[PROD_W-2:0], 1'b0};
      mplier_q <= {1'b0, mplier_q[MPLR_W-1:1]};
      acc_q    <= acc_d;
    end
  end

  assign product_o = $signed(acc_q);
  assign done_o    = done_q;

endmodule

>>> hdl/speed_pi_loop_with_filter_top.sv
// Speed PI loop: low-pass filtered wheel speed, clamped integral, PI output.
// One item is in flight at a time; each item runs the bit-serial multiplier
// three times, for the filter step, the integral term and the proportional term.
// Next input is taken while a finished result still waits on the output.
// Reset (async, active low) clears filter, integral and handshakes; registers
// return to their documented defaults. Depends on spl_pkg, spl_mul.
module speed_pi_loop_with_filter_top import spl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // left_count[15:0], right_count[31:16], pitch_angle[48:32],
  // forward_cmd[49], backward_cmd[50], zero[55:51]
  input  logic [55:0] s_axis_tdata,
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // drive_value[15:0], integral_term[31:16]
  output logic [31:0] m_axis_tdata
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_FILT   = 3'd1;
  localparam logic [2:0] ST_ISUM   = 3'd2;
  localparam logic [2:0] ST_ICLAMP = 3'd3;
  localparam logic [2:0] ST_MULI   = 3'd4;
  localparam logic [2:0] ST_MULP   = 3'd5;
  localparam logic [2:0] ST_OUT    = 3'd6;

  localparam int QW = PROD_W - 2 * FRAC_BITS;
  localparam logic signed [QW-1:0] Q_MAX = QW'(2 ** (OUT_W - 1) - 1);
  localparam logic signed [QW-1:0] Q_MIN = ~Q_MAX;
  localparam int MOV_W = 10 + FRAC_BITS + 1;

  function automatic logic [OUT_W-1:0] trunc_sat(input logic signed [PROD_W-1:0] x);
    logic signed [PROD_W-1:0] biased;
    logic signed [QW-1:0]     q;
    biased = x + (x[PROD_W-1] ? PROD_W'((1 << (2 * FRAC_BITS)) - 1) : PROD_W'(0));
    q      = biased[PROD_W-1:2*FRAC_BITS];
    if (q > Q_MAX) begin
      return Q_MAX[OUT_W-1:0];
    end else if (q < Q_MIN) begin
      return Q_MIN[OUT_W-1:0];
    end
    return q[OUT_W-1:0];
  endfunction

  // configuration
  logic signed [15:0] prop_gain_q, integ_gain_q;
  logic [14:0]        integ_lim_q;
  logic [9:0]         move_speed_q;
  logic [15:0]        tilt_lim_q;
  logic               cfg_wr;

  // datapath state
  logic [2:0]                 state_q;
  logic signed [FILT_W-1:0]   filt_q;
  logic signed [INTEG_W-1:0]  integ_q;
  logic signed [MCAND_W-1:0]  isum_q;
  logic signed [PROD_W-1:0]   prod_i_q;
  logic                       fwd_q, bwd_q, tilt_hit_q;
  logic                       m_valid_q;
  logic [31:0]                m_data_q;

  logic                       s_fire, out_free;
  logic signed [SUM_W-1:0]    sum;
  logic signed [MCAND_W-1:0]  diff;
  logic signed [17:0]         pitch_ext, tilt_ext;
  logic signed [MOV_W-1:0]    mov_pos, mov;
  logic signed [MCAND_W-1:0]  lim, isum_d;
  logic signed [INTEG_W-1:0]  integ_clamp;
  logic signed [FILT_W-1:0]   filt_step;

  mul_cmd_t                   mul_cmd;
  logic signed [MCAND_W-1:0]  mul_a;
  logic signed [MPLR_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]   mul_p;
  logic                       mul_done;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q  <= '0;
      integ_gain_q <= '0;
      integ_lim_q  <= 15'd10000;
      move_speed_q <= 10'd150;
      tilt_lim_q   <= 16'd10240;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_PROP_GAIN:  prop_gain_q  <= pwdata[15:0];
        REG_INTEG_GAIN: integ_gain_q <= pwdata[15:0];
        REG_INTEG_LIM:  integ_lim_q  <= pwdata[14:0];
        REG_MOVE_SPEED: move_speed_q <= pwdata[9:0];
        REG_TILT_LIM:   tilt_lim_q   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_PROP_GAIN:  prdata = {16'b0, prop_gain_q};
      REG_INTEG_GAIN: prdata = {16'b0, integ_gain_q};
      REG_INTEG_LIM:  prdata = {17'b0, integ_lim_q};
      REG_MOVE_SPEED: prdata = {22'b0, move_speed_q};
      REG_TILT_LIM:   prdata = {16'b0, tilt_lim_q};
      default:        prdata = '0;
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  assign sum  = SUM_W'($signed(s_axis_tdata[15:0])) + SUM_W'($signed(s_axis_tdata[31:16]));
  assign diff = MCAND_W'($signed({sum, {FRAC_BITS{1'b0}}})) - MCAND_W'(filt_q);

  assign pitch_ext = 18'($signed(s_axis_tdata[48:32]));
  assign tilt_ext  = $signed({2'b0, tilt_lim_q});

  assign mov_pos = $signed({1'b0, move_speed_q, {FRAC_BITS{1'b0}}});
  assign mov     = fwd_q ? -mov_pos : (bwd_q ? mov_pos : '0);
  assign isum_d  = MCAND_W'(integ_q) + MCAND_W'(filt_q) - MCAND_W'(mov);

  assign lim = $signed(MCAND_W'({integ_lim_q, {FRAC_BITS{1'b0}}}));
  always_comb begin
    if (isum_q > lim) begin
      integ_clamp = lim[INTEG_W-1:0];
    end else if (isum_q < -lim) begin
      integ_clamp = -lim[INTEG_W-1:0];
    end else begin
      integ_clamp = isum_q[INTEG_W-1:0];
    end
  end

  assign filt_step = mul_p[FILT_W+FRAC_BITS-1:FRAC_BITS];

  always_comb begin
    mul_cmd = '0;
    mul_a   = '0;
    mul_b   = '0;
    case (state_q)
      ST_IDLE: begin
        mul_cmd.start = s_fire;
        mul_a         = diff;
        mul_b         = MPLR_W'(COEF_NEW);
      end
      ST_ICLAMP: begin
        mul_cmd.start = 1'b1;
        mul_a         = MCAND_W'(integ_clamp);
        mul_b         = integ_gain_q;
      end
      ST_MULI: begin
        mul_cmd.start      = mul_done;
        mul_cmd.accumulate = 1'b1;
        mul_a              = MCAND_W'(filt_q);
        mul_b              = prop_gain_q;
      end
      default: ;
    endcase
  end

  spl_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (mul_cmd),
    .mcand_i   (mul_a),
    .mplier_i  (mul_b),
    .product_o (mul_p),
    .done_o    (mul_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      filt_q    <= '0;
      integ_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_OUT && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_fire) begin
            state_q <= ST_FILT;
          end
        end
        ST_FILT: begin
          if (mul_done) begin
            filt_q  <= filt_q + filt_step;
            state_q <= ST_ISUM;
          end
        end
        ST_ISUM: begin
          state_q <= ST_ICLAMP;
        end
        ST_ICLAMP: begin
          integ_q <= integ_clamp;
          state_q <= ST_MULI;
        end
        ST_MULI: begin
          if (mul_done) begin
            state_q <= ST_MULP;
          end
        end
        ST_MULP: begin
          if (mul_done) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            if (tilt_hit_q) begin
              integ_q <= '0;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      fwd_q      <= s_axis_tdata[49];
      bwd_q      <= s_axis_tdata[50];
      tilt_hit_q <= (pitch_ext > tilt_ext) || (pitch_ext < -tilt_ext);
    end
    if (state_q == ST_ISUM) begin
      isum_q <= isum_d;
    end
    if (state_q == ST_MULI && mul_done) begin
      prod_i_q <= mul_p;
    end
    if (state_q == ST_OUT && out_free) begin
      m_data_q <= {tilt_hit_q ? OUT_W'(0) : trunc_sat(prod_i_q), trunc_sat(mul_p)};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

>>> hdl/spl_checker.sv
// Port-level checks for speed_pi_loop_with_filter_top, attached by bind.
// Depends on the top level's port list only.
module spl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        pready,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");

  // one item in flight: input closes after a transfer
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while busy");

  // a new result appears only as the loop returns to waiting for input
  a_done_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result raised while still busy");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

endmodule

bind speed_pi_loop_with_filter_top spl_checker u_spl_checker (.*);
